// ===== hdl/base64_stream_decoder_macros.svh =====
// Assertion macros for the base64 stream decoder.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define B64D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define B64D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define B64D_ASSERT_IMP(lbl, ante, cons, msg)
`define B64D_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/b64d_pkg.sv =====
// Shared types, constants and the character decoder of the base64 stream decoder.
// No dependencies.
package b64d_pkg;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CHAR_D0    = 8'h30;
  localparam logic [7:0] CHAR_D9    = 8'h39;

  // Group queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef logic [QAW-1:0] qptr_t;
  typedef logic [QAW:0]   qcnt_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_PAD,
    KIND_BAD
  } char_kind_e;

  typedef struct packed {
    char_kind_e  kind;
    logic [5:0]  value;
  } decode_t;

  // One result word as seen on the output ports.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       bad_char;
    logic       end_of_run;
  } res_t;

  // All result words caused by one input word; num is 1 to 3.
  typedef struct packed {
    logic [1:0]      num;
    res_t [2:0]      slot;
  } group_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Maps a character to its sextet value and class.
  function automatic decode_t decode_char(logic [7:0] c);
    decode_t d;
    d.kind  = KIND_BAD;
    d.value = '0;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      d.kind  = KIND_DATA;
      d.value = 6'(c - CHAR_UP_A);
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      d.kind  = KIND_DATA;
      d.value = 6'(c - CHAR_LO_A + 8'd26);
    end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
      d.kind  = KIND_DATA;
      d.value = 6'(c - CHAR_D0 + 8'd52);
    end else if (c == CHAR_PLUS) begin
      d.kind  = KIND_DATA;
      d.value = 6'd62;
    end else if (c == CHAR_SLASH) begin
      d.kind  = KIND_DATA;
      d.value = 6'd63;
    end else if (c == CHAR_PAD) begin
      d.kind  = KIND_PAD;
    end
    return d;
  endfunction

endpackage

// ===== hdl/base64_stream_decoder.sv =====
// Streaming base64 decoder: one character word accepted per cycle, up to three
// result words per character, handed out one per cycle by the back end while pop is high.
// A character's results are stored in the group queue and reach the output ports from its head.
// Throughput: one character per cycle while the four-entry group queue has room;
// the back end drains one result word per cycle while pop is high.
// Reset (rst_ni low, asynchronous) empties the queue and clears the open group.
`include "base64_stream_decoder_macros.svh"

module base64_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code_i,
  input  logic       is_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       bad_char_o,
  output logic       end_of_run_o
);

  b64d_pkg::group_t     front_group, head_group;
  logic                 front_valid, accept, q_pop;
  b64d_pkg::q_status_t  q_status;
  b64d_pkg::res_t       res;

  assign accept = push && !full;
  assign full   = q_status.full;
  assign empty  = q_status.empty;

  // Character classification and group building.
  b64d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .char_code_i   (char_code_i),
    .is_last_i     (is_last_i),
    .group_o       (front_group),
    .group_valid_o (front_valid)
  );

  // Queue of result groups.
  b64d_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (accept && front_valid),
    .wr_group_i (front_group),
    .rd_en_i    (q_pop),
    .rd_group_o (head_group),
    .status_o   (q_status)
  );

  // Result word sequencing.
  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_group),
    .head_valid_i (!q_status.empty),
    .pop_i        (pop),
    .res_o        (res),
    .q_pop_o      (q_pop)
  );

  assign data_byte_o  = res.data_byte;
  assign byte_valid_o = res.byte_valid;
  assign bad_char_o   = res.bad_char;
  assign end_of_run_o = res.end_of_run;

  // A last character always leaves at least one result behind.
  `B64D_ASSERT_NXT(a_last_gives_result, accept && is_last_i, !empty, "last word lost")
  // A word without a byte is an error report or an end marker.
  `B64D_ASSERT_IMP(a_no_empty_word, !empty && !byte_valid_o, bad_char_o || end_of_run_o, "empty word")
  // A byte and an error are never reported together.
  `B64D_ASSERT_IMP(a_byte_xor_bad, !empty, !(byte_valid_o && bad_char_o), "byte with error")
  // A full queue always has a head group on offer.
  `B64D_ASSERT_IMP(a_full_not_empty, full, !empty, "full and empty")

endmodule

// ===== hdl/b64d_front.sv =====
// Front end: classifies each character, keeps the open sextet group and
// builds the group of result words that the character causes. Uses b64d_pkg.
module b64d_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          char_code_i,
  input  logic                is_last_i,
  output b64d_pkg::group_t    group_o,
  output logic                group_valid_o
);

  logic [17:0]           acc_q, acc_d;
  logic [1:0]            cnt_q, cnt_d;
  b64d_pkg::decode_t     dec;
  logic [23:0]           word;
  logic [1:0]            n;

  assign dec  = b64d_pkg::decode_char(char_code_i);
  assign word = {acc_q, dec.value};

  // Build the result group and the next group state.
  always_comb begin
    group_o = '0;
    n       = 2'd0;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    unique case (dec.kind)
      b64d_pkg::KIND_BAD: begin
        group_o.slot[n].bad_char = 1'b1;
        n = n + 2'd1;
      end
      b64d_pkg::KIND_DATA: begin
        if (cnt_q == 2'd3) begin
          group_o.slot[0].data_byte  = word[23:16];
          group_o.slot[0].byte_valid = 1'b1;
          group_o.slot[1].data_byte  = word[15:8];
          group_o.slot[1].byte_valid = 1'b1;
          group_o.slot[2].data_byte  = word[7:0];
          group_o.slot[2].byte_valid = 1'b1;
          n     = 2'd3;
          acc_d = '0;
          cnt_d = 2'd0;
        end else begin
          acc_d = {acc_q[11:0], dec.value};
          cnt_d = cnt_q + 2'd1;
        end
      end
      b64d_pkg::KIND_PAD: begin
      end
      default: begin
      end
    endcase

    // The last character flushes a partial group and closes the run.
    if (is_last_i) begin
      if (cnt_d == 2'd2) begin
        group_o.slot[n].data_byte  = acc_d[11:4];
        group_o.slot[n].byte_valid = 1'b1;
        n = n + 2'd1;
      end else if (cnt_d == 2'd3) begin
        group_o.slot[n].data_byte  = acc_d[17:10];
        group_o.slot[n].byte_valid = 1'b1;
        n = n + 2'd1;
        group_o.slot[n].data_byte  = acc_d[9:2];
        group_o.slot[n].byte_valid = 1'b1;
        n = n + 2'd1;
      end
      if (n == 2'd0) begin
        n = 2'd1;
      end
      group_o.slot[n - 2'd1].end_of_run = 1'b1;
      acc_d = '0;
      cnt_d = 2'd0;
    end
    group_o.num = n;
  end

  assign group_valid_o = (n != 2'd0);

  // Group state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= 2'd0;
    end else if (accept_i) begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hdl/b64d_queue.sv =====
// Short queue of result groups between the front and back ends.
// Uses b64d_pkg.
module b64d_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  b64d_pkg::group_t      wr_group_i,
  input  logic                  rd_en_i,
  output b64d_pkg::group_t      rd_group_o,
  output b64d_pkg::q_status_t   status_o
);

  b64d_pkg::group_t   mem_q [b64d_pkg::QDEPTH];
  b64d_pkg::qptr_t    wr_ptr_q, wr_ptr_d;
  b64d_pkg::qptr_t    rd_ptr_q, rd_ptr_d;
  b64d_pkg::qcnt_t    count_q, count_d;
  logic               do_wr, do_rd;

  assign status_o.full  = (count_q == b64d_pkg::qcnt_t'(b64d_pkg::QDEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_wr = wr_en_i && !status_o.full;
  assign do_rd = rd_en_i && !status_o.empty;
  assign rd_group_o = mem_q[rd_ptr_q];

  // Pointer and fill count updates with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == b64d_pkg::qptr_t'(b64d_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_q + b64d_pkg::qptr_t'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == b64d_pkg::qptr_t'(b64d_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_q + b64d_pkg::qptr_t'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + b64d_pkg::qcnt_t'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - b64d_pkg::qcnt_t'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Group storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_group_i;
    end
  end

endmodule

// ===== hdl/b64d_back.sv =====
// Back end: hands out the words of the oldest queued group one at a time.
// Uses b64d_pkg.
module b64d_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  b64d_pkg::group_t      head_i,
  input  logic                  head_valid_i,
  input  logic                  pop_i,
  output b64d_pkg::res_t        res_o,
  output logic                  q_pop_o
);

  logic [1:0] idx_q, idx_d;
  logic       take, last_slot;

  assign res_o     = head_i.slot[idx_q];
  assign take      = pop_i && head_valid_i;
  assign last_slot = (idx_q == head_i.num - 2'd1);
  assign q_pop_o   = take && last_slot;

  // Step through the words of the head group.
  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = last_slot ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
